>>> rtl/bcart_pkg.sv
// Types and constants shared by the banked ROM cartridge mapper.
package bcart_pkg;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_SAVE,
    ST_WIPE
  } state_t;

  typedef enum logic [1:0] {
    SWP_NONE,
    SWP_LOAD,
    SWP_SAVE,
    SWP_WIPE
  } sweep_t;

  typedef enum logic [2:0] {
    RES_VALUE,
    RES_RAM,
    RES_ROM,
    RES_ROM_SET,
    RES_ROM_CLR
  } res_sel_t;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_PATCH = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  localparam logic [3:0] OP_TUNE = 4'd1;
  localparam logic [3:0] OP_LOAD = 4'd2;
  localparam logic [3:0] OP_SAVE = 4'd3;
  localparam logic [3:0] OP_WIPE = 4'd4;
  localparam logic [3:0] TUNE_LIMIT = 4'd7;

  localparam logic [11:0] ADDR_READ_WIN   = 12'h040;
  localparam logic [11:0] ADDR_ROM        = 12'h080;
  localparam logic [11:0] ADDR_OP_HOT     = 12'hFF4;
  localparam logic [11:0] ADDR_BANK_FIRST = 12'hFF5;
  localparam logic [11:0] ADDR_BANK_LAST  = 12'hFFB;
  localparam logic [11:0] ADDR_FIRST_RAM  = 12'h004;

  localparam logic [5:0] OFF_STUB_ONES  = 6'd1;
  localparam logic [5:0] OFF_STUB_ZERO0 = 6'd2;
  localparam logic [5:0] OFF_STUB_ZERO1 = 6'd3;

  localparam logic [7:0] BUSY_BIT  = 8'h40;
  localparam logic [7:0] STUB_ONES = 8'hFF;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_READ_DELAY  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_DELAY = 8'd1;

  localparam logic [23:0] READ_DELAY_RESET  = 24'd500000;
  localparam logic [23:0] WRITE_DELAY_RESET = 24'd1000000;

endpackage

>>> rtl/banked_rom_cart_with_ram_ports.sv
// Banked ROM cartridge mapper with a small RAM and a slow score store.
// Each request (bus read, bus write, patch or tick) is taken in ST_IDLE:
// the accept cycle issues the synchronous ROM and RAM reads and the writes,
// and the next cycle (ST_EXEC) forms the result byte from the registered
// read data. A further request is accepted only once the mapper is back in
// ST_IDLE with the skid register empty, so requests are handled one at a
// time. A hotspot access that starts a score slice load or save then runs
// a copy over the RAM and score memories, and a wipe clears the score
// store; no request is accepted during a copy or a wipe. After reset a
// clearing pass sets up the score store and the RAM before the first
// request is accepted; configuration writes are taken at any time. The ROM
// is not cleared and must be patched before it is read.
module banked_rom_cart_with_ram_ports import bcart_pkg::*; #(
  parameter int BANK_COUNT  = 8,
  parameter int RAM_BYTES   = 64,
  parameter int SCORE_BYTES = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // address [11:0], write_data [19:12], bus_value [27:20], zero [31:28]
  input  logic [31:0]            s_tdata,
  // mode [1:0]
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // read_data [7:0]
  output logic [7:0]             m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [23:0]            cfg_data
);

  localparam int BW        = $clog2(BANK_COUNT);
  localparam int ROM_AW    = BW + 12;
  localparam int ROM_DEPTH = BANK_COUNT * 4096;
  localparam int RAW       = $clog2(RAM_BYTES);
  localparam int SAW       = $clog2(SCORE_BYTES);
  localparam int CW        = $clog2(SCORE_BYTES + 1);
  localparam int SLICES    = SCORE_BYTES / RAM_BYTES;

  localparam logic [BW-1:0] BANK_RESET = BW'(1 % BANK_COUNT);
  localparam logic [BW-1:0] BANK_SEL [8] = '{
    BW'(0), BW'(1 % BANK_COUNT), BW'(2 % BANK_COUNT), BW'(3 % BANK_COUNT),
    BW'(4 % BANK_COUNT), BW'(5 % BANK_COUNT), BW'(6 % BANK_COUNT),
    BW'(7 % BANK_COUNT)
  };

  function automatic logic [RAW-1:0] ram_wrap(input logic [5:0] a);
    logic [6:0] v;
    v = {1'b0, a};
    for (int k = 0; k < 3; k++) begin
      if (v >= 7'(RAM_BYTES)) begin
        v = v - 7'(RAM_BYTES);
      end
    end
    return v[RAW-1:0];
  endfunction

  logic [7:0] rom_mem   [ROM_DEPTH];
  logic [7:0] ram_mem   [RAM_BYTES];
  logic [7:0] score_mem [SCORE_BYTES];

  state_t            state, state_next;
  logic [BW-1:0]     bank;
  logic [7:0]        op_byte;
  logic              busy;
  logic [23:0]       ticks;
  logic [23:0]       rd_delay;
  logic [23:0]       wr_delay;
  sweep_t            sweep;
  logic [SAW-1:0]    slice_base;
  res_sel_t          res_sel;
  logic [7:0]        res_val;
  logic [7:0]        res_data;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     prev;
  logic              prev_vld;
  logic              pend_valid;
  logic [7:0]        pend_data;

  logic              rom_we;
  logic [ROM_AW-1:0] rom_wa, rom_ra;
  logic [7:0]        rom_q;
  logic              ram_we;
  logic [RAW-1:0]    ram_wa, ram_ra;
  logic [7:0]        ram_wd, ram_q;
  logic              score_we;
  logic [SAW-1:0]    score_wa, score_ra;
  logic [7:0]        score_wd, score_q;

  logic [1:0]        in_mode;
  logic [11:0]       in_addr;
  logic [7:0]        in_wdata;
  logic [7:0]        in_bus;
  logic              accept;
  logic              bus_access;
  logic              is_op;
  logic              is_bank_hot;
  logic [2:0]        bank_idx;
  logic [BW-1:0]     bank_eff;
  logic [3:0]        op_idx;
  logic [3:0]        op_code;
  logic              slice_ok;
  logic              op_start;
  logic              op_done;
  logic              out_free;

  assign in_mode  = s_tuser;
  assign in_addr  = s_tdata[11:0];
  assign in_wdata = s_tdata[19:12];
  assign in_bus   = s_tdata[27:20];

  assign s_tready  = (state == ST_IDLE) && !pend_valid;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  assign bus_access  = (in_mode == MODE_READ) || (in_mode == MODE_WRITE);
  assign is_op       = bus_access && (in_addr == ADDR_OP_HOT);
  assign is_bank_hot = bus_access && (in_addr >= ADDR_BANK_FIRST) &&
                       (in_addr <= ADDR_BANK_LAST);
  assign bank_idx    = 3'(in_addr[2:0] - 3'd4);
  assign bank_eff    = is_bank_hot ? BANK_SEL[bank_idx] : bank;

  assign op_idx   = op_byte[7:4];
  assign op_code  = op_byte[3:0];
  assign slice_ok = 32'(op_idx) < SLICES;
  assign op_done  = busy && (ticks == '0);

  always_comb begin
    op_start = 1'b0;
    if (!busy) begin
      case (op_code)
        OP_TUNE: op_start = op_idx < TUNE_LIMIT;
        OP_LOAD, OP_SAVE: op_start = slice_ok;
        OP_WIPE: op_start = 1'b1;
        default: op_start = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    rom_we     = 1'b0;
    rom_wa     = {bank, in_addr};
    rom_ra     = {bank_eff, in_addr};
    ram_we     = 1'b0;
    ram_wa     = ram_wrap(in_addr[5:0]);
    ram_wd     = in_wdata;
    ram_ra     = ram_wrap(in_addr[5:0]);
    score_we   = 1'b0;
    score_wa   = SAW'(slice_base + prev[SAW-1:0]);
    score_wd   = ram_q;
    score_ra   = SAW'(slice_base + cnt[SAW-1:0]);
    case (state)
      ST_INIT: begin
        score_we = 1'b1;
        score_wa = cnt[SAW-1:0];
        score_wd = '0;
        ram_we   = cnt < CW'(RAM_BYTES);
        ram_wa   = cnt[RAW-1:0];
        ram_wd   = (cnt < CW'(4)) ? STUB_ONES : '0;
        if (cnt == CW'(SCORE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
          case (in_mode)
            MODE_READ: begin
              if (in_addr < ADDR_READ_WIN) begin
                ram_we = 1'b1;
                ram_wd = in_bus;
              end else if (is_op && op_done) begin
                ram_we = 1'b1;
                ram_wa = '0;
                ram_wd = '0;
              end
            end
            MODE_WRITE: begin
              if ((in_addr < ADDR_READ_WIN) && (in_addr >= ADDR_FIRST_RAM)) begin
                ram_we = 1'b1;
              end else if (is_op && op_done) begin
                ram_we = 1'b1;
                ram_wa = '0;
                ram_wd = '0;
              end
            end
            MODE_PATCH: begin
              if (in_addr < ADDR_ROM) begin
                ram_we = 1'b1;
              end else begin
                rom_we = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EXEC: begin
        case (sweep)
          SWP_LOAD: state_next = ST_LOAD;
          SWP_SAVE: state_next = ST_SAVE;
          SWP_WIPE: state_next = ST_WIPE;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_LOAD: begin
        ram_we = prev_vld;
        ram_wa = prev[RAW-1:0];
        ram_wd = score_q;
        if (cnt == CW'(RAM_BYTES)) begin
          state_next = ST_IDLE;
        end
      end
      ST_SAVE: begin
        ram_ra   = (cnt < CW'(RAM_BYTES)) ? cnt[RAW-1:0] : '0;
        score_we = prev_vld;
        if (cnt == CW'(RAM_BYTES)) begin
          state_next = ST_IDLE;
        end
      end
      ST_WIPE: begin
        score_we = 1'b1;
        score_wa = cnt[SAW-1:0];
        score_wd = '0;
        if (cnt == CW'(SCORE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[rom_wa] <= in_wdata;
    end
    rom_q <= rom_mem[rom_ra];
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_wa] <= ram_wd;
    end
    ram_q <= ram_mem[ram_ra];
  end

  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[score_wa] <= score_wd;
    end
    score_q <= score_mem[score_ra];
  end

  always_comb begin
    case (res_sel)
      RES_VALUE:   res_data = res_val;
      RES_RAM:     res_data = ram_q;
      RES_ROM:     res_data = rom_q;
      RES_ROM_SET: res_data = rom_q | BUSY_BIT;
      RES_ROM_CLR: res_data = rom_q & ~BUSY_BIT;
      default:     res_data = res_val;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank       <= BANK_RESET;
      op_byte    <= '0;
      busy       <= 1'b0;
      ticks      <= '0;
      rd_delay   <= READ_DELAY_RESET;
      wr_delay   <= WRITE_DELAY_RESET;
      sweep      <= SWP_NONE;
      cnt        <= '0;
      prev_vld   <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_READ_DELAY) begin
          rd_delay <= cfg_data;
        end else if (cfg_index == CFG_WRITE_DELAY) begin
          wr_delay <= cfg_data;
        end
      end

      prev <= cnt;
      if (state inside {ST_INIT, ST_LOAD, ST_SAVE, ST_WIPE}) begin
        cnt      <= CW'(cnt + 1'b1);
        prev_vld <= (state inside {ST_LOAD, ST_SAVE}) && (cnt < CW'(RAM_BYTES));
      end else begin
        cnt      <= '0;
        prev_vld <= 1'b0;
      end

      if (accept) begin
        sweep   <= SWP_NONE;
        res_sel <= RES_VALUE;
        res_val <= '0;
        case (in_mode)
          MODE_READ: begin
            if (in_addr < ADDR_READ_WIN) begin
              res_val <= in_bus;
            end else if (in_addr < ADDR_ROM) begin
              case (in_addr[5:0])
                OFF_STUB_ONES: res_val <= STUB_ONES;
                OFF_STUB_ZERO0, OFF_STUB_ZERO1: res_val <= '0;
                default: res_sel <= RES_RAM;
              endcase
            end else if (is_op) begin
              res_sel <= op_done ? RES_ROM_CLR : RES_ROM_SET;
            end else begin
              res_sel <= RES_ROM;
            end
          end
          MODE_WRITE: begin
            if (in_addr == '0) begin
              op_byte <= in_wdata;
            end
          end
          MODE_TICK: begin
            if (ticks != '0) begin
              ticks <= ticks - 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (is_bank_hot) begin
          bank <= BANK_SEL[bank_idx];
        end

        if (is_op) begin
          if (op_start) begin
            busy       <= 1'b1;
            slice_base <= SAW'(op_idx * RAM_BYTES);
            if ((op_code == OP_SAVE) || (op_code == OP_WIPE)) begin
              ticks <= wr_delay;
            end else begin
              ticks <= rd_delay;
            end
            case (op_code)
              OP_LOAD: sweep <= SWP_LOAD;
              OP_SAVE: sweep <= SWP_SAVE;
              OP_WIPE: sweep <= SWP_WIPE;
              default: sweep <= SWP_NONE;
            endcase
          end else if (op_done) begin
            busy <= 1'b0;
          end
        end
      end

      if (out_free) begin
        if (pend_valid) begin
          m_tvalid   <= 1'b1;
          m_tdata    <= pend_data;
          pend_valid <= 1'b0;
        end else if (state == ST_EXEC) begin
          m_tvalid <= 1'b1;
          m_tdata  <= res_data;
        end else begin
          m_tvalid <= 1'b0;
        end
      end else if (state == ST_EXEC) begin
        pend_valid <= 1'b1;
        pend_data  <= res_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> m_tvalid)
    else $error("Skid register holds a result while the output is empty.");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("Accepted request did not move to the result cycle.");

  a_exec_skid_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !pend_valid)
    else $error("Result cycle found the skid register occupied.");
`endif

endmodule
